/* hdl/aat_pkg.sv */
`default_nettype none
package aat_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 32;
  localparam int TAG_W   = 16;
  localparam int LINE_W  = 20;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  // Input tdata: address, block_size, source_tag, line_number (100 bits, padded to 104)
  localparam int S_TDATA_W = 104;
  // Input tuser: kind, is_array
  localparam int S_TUSER_W = 3;
  // Output tdata: address, size, tag, line, live_count (107 bits, padded to 112)
  localparam int M_TDATA_W = 112;
  localparam int M_TUSER_W = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd2;

  localparam logic [STAT_W-1:0] ST_RECORDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOALLOC  = 3'd4;
  localparam logic [STAT_W-1:0] ST_LEAK     = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEAN    = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic              is_array;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/allocation_tracking_table.sv */
// Allocate: the slot walk checks one valid bit per cycle up to the first free or last slot.
// Free: a live slot costs a table read plus a compare, an empty slot only its valid-bit
// check. Leak scan: one CLEAN result when clean, else one LEAK result per live entry.
// Each result is registered and leaves the cycle after its deciding walk cycle; a stalled
// result holds the walk. A new item is accepted only in idle, once the result is posted.
// Reset (rst, synchronous, active high) clears valid bits, live count and output valid.
`default_nettype none
module allocation_tracking_table
  import aat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [31:0] address, [63:32] block_size, [79:64] source_tag, [99:80] line_number
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] kind, [2] is_array
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] report_address, [63:32] report_size, [79:64] report_tag,
  // [99:80] report_line, [106:100] live_count
  output logic [M_TDATA_W-1:0]      m_tdata,
  // [2:0] status
  output logic [M_TUSER_W-1:0]      m_tuser,
  output logic                      m_tlast
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ALLOC     = 3'd1;
  localparam logic [2:0] S_FREE_SEEK = 3'd2;
  localparam logic [2:0] S_FREE_CMP  = 3'd3;
  localparam logic [2:0] S_SCAN_SEEK = 3'd4;
  localparam logic [2:0] S_SCAN_EMIT = 3'd5;

  logic [2:0]             state;
  logic [IDX_W-1:0]       idx;        // slot under test, also the table read address
  logic [COUNT_W-1:0]     sent;       // leak results already handed out in this scan
  logic [COUNT_W-1:0]     live;
  logic [TABLE_DEPTH-1:0] valid;

  // Request held for the duration of the walk
  logic [ADDR_W-1:0] req_addr;
  logic [SIZE_W-1:0] req_size;
  logic [TAG_W-1:0]  req_tag;
  logic [LINE_W-1:0] req_line;
  logic              req_arr;

  // Table storage: one write port, one registered read port
  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic   mem_we;
  entry_t wr_entry;

  // Output register fields
  logic [STAT_W-1:0]  out_status;
  logic [ADDR_W-1:0]  out_addr;
  logic [SIZE_W-1:0]  out_size;
  logic [TAG_W-1:0]   out_tag;
  logic [LINE_W-1:0]  out_line;
  logic [COUNT_W-1:0] out_live;
  logic               out_last;

  logic in_xfer;
  logic out_free;     // output register empty or being drained this cycle
  logic addr_hit;
  logic scan_last;
  logic emit;         // a result is loaded into the output register at this edge

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign addr_hit = (rd_q.address == req_addr);
  assign scan_last = ((sent + 7'd1) == live);

  assign emit = out_free && (
      ((state == S_ALLOC) && (!valid[idx] || (idx == LAST_SLOT))) ||
      ((state == S_FREE_SEEK) && !valid[idx] && (idx == LAST_SLOT)) ||
      ((state == S_FREE_CMP) && (addr_hit || (idx == LAST_SLOT))) ||
      ((state == S_SCAN_SEEK) && (live == '0)) ||
      (state == S_SCAN_EMIT));

  assign m_tdata = {5'd0, out_live, out_line, out_tag, out_size, out_addr};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // Allocate writes the first free slot once the result can be posted
  assign mem_we = (state == S_ALLOC) && !valid[idx] && out_free;
  assign wr_entry = '{address: req_addr, size: req_size, tag: req_tag,
                      line: req_line, is_array: req_arr};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wr_entry;
    end
    rd_q <= mem[idx];
  end

  // Output valid: set on a new result, drop once the held one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      sent     <= '0;
      live     <= '0;
      valid    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            req_addr <= s_tdata[31:0];
            req_size <= s_tdata[63:32];
            req_tag  <= s_tdata[79:64];
            req_line <= s_tdata[99:80];
            req_arr  <= s_tuser[2];
            idx      <= '0;
            sent     <= '0;
            case (s_tuser[1:0])
              KIND_ALLOC: state <= S_ALLOC;
              KIND_FREE:  state <= S_FREE_SEEK;
              KIND_SCAN:  state <= S_SCAN_SEEK;
              default:    state <= S_IDLE;  // unused kind: drop the transfer
            endcase
          end
        end

        S_ALLOC: begin
          if (!valid[idx]) begin
            if (out_free) begin
              valid[idx] <= 1'b1;
              live       <= live + 7'd1;
              out_status <= ST_RECORDED;
              out_addr   <= req_addr;
              out_size   <= req_size;
              out_tag    <= req_tag;
              out_line   <= req_line;
              out_live   <= live + 7'd1;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else if (idx == LAST_SLOT) begin
            if (out_free) begin
              out_status <= ST_FULL;
              out_addr   <= req_addr;
              out_size   <= '0;
              out_tag    <= '0;
              out_line   <= '0;
              out_live   <= live;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FREE_SEEK: begin
          if (valid[idx]) begin
            state <= S_FREE_CMP;   // read of this slot lands next cycle
          end else if (idx == LAST_SLOT) begin
            if (out_free) begin
              out_status <= ST_NOALLOC;
              out_addr   <= req_addr;
              out_size   <= '0;
              out_tag    <= '0;
              out_line   <= '0;
              out_live   <= live;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FREE_CMP: begin
          if (addr_hit) begin
            if (out_free) begin
              out_addr <= req_addr;
              out_size <= rd_q.size;
              out_tag  <= rd_q.tag;
              out_line <= rd_q.line;
              out_last <= 1'b1;
              if (rd_q.is_array != req_arr) begin
                out_status <= ST_MISMATCH;
                out_live   <= live;
              end else begin
                valid[idx] <= 1'b0;
                live       <= live - 7'd1;
                out_status <= ST_FREED;
                out_live   <= live - 7'd1;
              end
              state <= S_IDLE;
            end
          end else if (idx == LAST_SLOT) begin
            if (out_free) begin
              out_status <= ST_NOALLOC;
              out_addr   <= req_addr;
              out_size   <= '0;
              out_tag    <= '0;
              out_line   <= '0;
              out_live   <= live;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FREE_SEEK;
          end
        end

        S_SCAN_SEEK: begin
          // Live count equals the number of valid bits, so the walk always
          // finds another entry while sent is below it.
          if (live == '0) begin
            if (out_free) begin
              out_status <= ST_CLEAN;
              out_addr   <= '0;
              out_size   <= '0;
              out_tag    <= '0;
              out_line   <= '0;
              out_live   <= live;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else if (valid[idx]) begin
            state <= S_SCAN_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_SCAN_EMIT: begin
          if (out_free) begin
            out_status <= ST_LEAK;
            out_addr   <= rd_q.address;
            out_size   <= rd_q.size;
            out_tag    <= rd_q.tag;
            out_line   <= rd_q.line;
            out_live   <= live;
            out_last   <= scan_last;
            if (scan_last) begin
              state <= S_IDLE;
            end else begin
              sent  <= sent + 7'd1;
              idx   <= idx + 1'b1;
              state <= S_SCAN_SEEK;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/aat_checker.sv */
`default_nettype none
module aat_checker
  import aat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TUSER_W-1:0] s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [M_TUSER_W-1:0] m_tuser,
  input wire logic                 m_tlast
);

  logic [COUNT_W-1:0] live_seen;
  assign live_seen = m_tdata[106:100];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (live_seen <= COUNT_W'(TABLE_DEPTH)))
    else $error("live count above table depth");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_LEAK) |-> m_tlast)
    else $error("non-leak result without last");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> (live_seen == COUNT_W'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

  // A transfer with a known kind starts a walk, so input ready drops
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && ((s_tuser[KIND_W-1:0] == KIND_ALLOC)
      || (s_tuser[KIND_W-1:0] == KIND_FREE) || (s_tuser[KIND_W-1:0] == KIND_SCAN))
      |=> !s_tready)
    else $error("input ready held after a transfer");

endmodule

bind allocation_tracking_table aat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_aat_checker (.*);
`default_nettype wire
